// ===== sv/assert_macros.svh =====
// Assertion macros for the checker module of the heat map block.
// No dependencies; included by files that write concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define GDH_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Assertion that is also checked during reset.
`define GDH_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/gdh_pkg.sv =====
// Package of the grid distance heat map: codes, sizes and shared structs.
// No dependencies; imported by the engine, the top level and the bench.
`timescale 1ns / 1ps

package gdh_pkg;

    localparam int DEF_MAX_ROWS = 128;
    localparam int DEF_MAX_COLS = 128;

    localparam int HEAT_W = 9;
    localparam logic signed [HEAT_W-1:0] HEAT_FLOOR = -9'sd256;
    localparam logic signed [HEAT_W-1:0] HEAT_SEED = 9'sd1;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_POS = 2'd1;
    localparam logic [1:0] MODE_NEG = 2'd2;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    // Stored owner signs.
    localparam logic [1:0] OWN_EMPTY = 2'b00;
    localparam logic [1:0] OWN_POS   = 2'b01;
    localparam logic [1:0] OWN_NEG   = 2'b11;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] row;
        logic [6:0] col;
        logic [1:0] owner;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rows;
        logic [7:0] cols;
    } t_cfg;

    typedef struct packed {
        logic signed [HEAT_W-1:0] heat;
        logic                     done;
    } t_res;

endpackage

// ===== sv/gdh_engine.sv =====
// Sequencer of the heat map with the owner and heat memories inside.
// Depends on gdh_pkg.
`timescale 1ns / 1ps

module gdh_engine
    import gdh_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_idle,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    output t_res  o_res
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CNW = $clog2(MAX_COLS + 1);
    localparam int SW  = $clog2(MAX_ROWS + MAX_COLS + 1) + 3;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RDH      = 4'd1;
    localparam logic [3:0] S_RES      = 4'd2;
    localparam logic [3:0] S_INIT_RD  = 4'd3;
    localparam logic [3:0] S_INIT_WR  = 4'd4;
    localparam logic [3:0] S_SCAN_RD  = 4'd5;
    localparam logic [3:0] S_SCAN_CHK = 4'd6;
    localparam logic [3:0] S_RING     = 4'd7;
    localparam logic [3:0] S_RING_WR  = 4'd8;

    logic [1:0]               owner_mem [DEPTH];
    logic signed [HEAT_W-1:0] heat_mem  [DEPTH];

    logic [3:0]               r_state, n_state;
    logic [RW-1:0]            r_sr, n_sr;
    logic [CW-1:0]            r_sc, n_sc;
    logic [RNW-1:0]           r_rows, n_rows;
    logic [CNW-1:0]           r_cols, n_cols;
    logic signed [SW-1:0]     r_lim, n_lim;
    logic signed [HEAT_W-1:0] r_empty, n_empty;
    logic signed [SW-1:0]     r_sz, n_sz, r_dr, n_dr, r_cc, n_cc;
    logic                     r_chg, n_chg;
    logic                     r_ingrid, n_ingrid;
    t_res                     r_res, n_res;

    logic [1:0]               r_ord;
    logic signed [HEAT_W-1:0] r_hrd;

    logic                     own_re, own_we, heat_re, heat_we;
    logic [AW-1:0]            own_raddr, own_waddr, heat_raddr, heat_waddr;
    logic [1:0]               own_wdata;
    logic signed [HEAT_W-1:0] heat_wdata;

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (own_we) begin
            owner_mem[own_waddr] <= own_wdata;
        end
        if (own_re) begin
            r_ord <= owner_mem[own_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (heat_we) begin
            heat_mem[heat_waddr] <= heat_wdata;
        end
        if (heat_re) begin
            r_hrd <= heat_mem[heat_raddr];
        end
    end

    // Item address.
    logic          item_ingrid;
    logic [AW-1:0] item_addr;
    assign item_ingrid = (32'(i_item.row) < MAX_ROWS) && (32'(i_item.col) < MAX_COLS);
    assign item_addr   = AW'(32'(i_item.row) * MAX_COLS + 32'(i_item.col));

    // Sizes saturated at compute start.
    logic [RNW-1:0]       sat_rows;
    logic [CNW-1:0]       sat_cols;
    logic signed [SW-1:0] sat_sum;
    always_comb begin
        if (i_cfg.rows == 8'd0) begin
            sat_rows = RNW'(1);
        end else if (32'(i_cfg.rows) > MAX_ROWS) begin
            sat_rows = RNW'(MAX_ROWS);
        end else begin
            sat_rows = RNW'(i_cfg.rows);
        end
        if (i_cfg.cols == 8'd0) begin
            sat_cols = CNW'(1);
        end else if (32'(i_cfg.cols) > MAX_COLS) begin
            sat_cols = CNW'(MAX_COLS);
        end else begin
            sat_cols = CNW'(i_cfg.cols);
        end
        sat_sum = SW'(sat_rows) + SW'(sat_cols);
    end

    // Raster position.
    logic [AW-1:0] scan_addr;
    logic          scan_last_col, scan_last;
    assign scan_addr     = AW'(AW'(r_sr) * AW'(MAX_COLS)) + AW'(r_sc);
    assign scan_last_col = (CNW'(r_sc) + CNW'(1)) == r_cols;
    assign scan_last     = scan_last_col && ((RNW'(r_sr) + RNW'(1)) == r_rows);

    // Ring walk around the seed at (r_sr, r_sc).
    logic signed [SW-1:0]     r0, c0, tr, tc, adr, adc, mdist;
    logic                     t_ok, row_edge, last_in_row;
    logic [AW-1:0]            t_addr;
    logic signed [HEAT_W-1:0] cand;
    always_comb begin
        r0   = signed'(SW'(r_sr));
        c0   = signed'(SW'(r_sc));
        tr   = r0 + r_dr;
        tc   = r_cc;
        t_ok = (tr >= 0) && (tr < signed'(SW'(r_rows)))
            && (tc >= 0) && (tc < signed'(SW'(r_cols)));
        adr  = (r_dr < 0) ? -r_dr : r_dr;
        adc  = (tc < c0) ? (c0 - tc) : (tc - c0);
        mdist = adr + adc;
        cand = (mdist > SW'(256)) ? HEAT_FLOOR : HEAT_W'(-mdist);
        t_addr = AW'(AW'(tr[RW-1:0]) * AW'(MAX_COLS)) + AW'(tc[CW-1:0]);
        row_edge    = (r_dr == -r_sz) || (r_dr == r_sz);
        last_in_row = (tc == c0 + r_sz);
    end

    logic signed [HEAT_W-1:0] init_heat;
    always_comb begin
        if (i_cfg.mode == MODE_OFF) begin
            init_heat = '0;
        end else if (r_ord == OWN_EMPTY) begin
            init_heat = r_empty;
        end else if ((r_ord == OWN_POS && i_cfg.mode == MODE_POS)
                  || (r_ord[1] && i_cfg.mode == MODE_NEG)) begin
            init_heat = HEAT_SEED;
        end else begin
            init_heat = '0;
        end
    end

    logic cell_raise;
    assign cell_raise = r_hrd < cand;

    always_comb begin
        n_state  = r_state;
        n_sr     = r_sr;
        n_sc     = r_sc;
        n_rows   = r_rows;
        n_cols   = r_cols;
        n_lim    = r_lim;
        n_empty  = r_empty;
        n_sz     = r_sz;
        n_dr     = r_dr;
        n_cc     = r_cc;
        n_chg    = r_chg;
        n_ingrid = r_ingrid;
        n_res    = r_res;

        own_re     = 1'b0;
        own_we     = 1'b0;
        own_raddr  = scan_addr;
        own_waddr  = item_addr;
        own_wdata  = (i_item.owner == 2'b00) ? OWN_EMPTY
                   : (i_item.owner[1] ? OWN_NEG : OWN_POS);
        heat_re    = 1'b0;
        heat_we    = 1'b0;
        heat_raddr = scan_addr;
        heat_waddr = scan_addr;
        heat_wdata = init_heat;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res.heat = '0;
                    n_res.done = 1'b1;
                    n_ingrid   = item_ingrid;
                    case (i_item.opcode)
                        OP_WRITE: begin
                            own_we  = item_ingrid;
                            n_state = S_RES;
                        end
                        OP_COMPUTE: begin
                            n_rows  = sat_rows;
                            n_cols  = sat_cols;
                            n_lim   = sat_sum;
                            n_empty = (sat_sum > SW'(256)) ? HEAT_FLOOR
                                                           : HEAT_W'(-sat_sum);
                            n_sr    = '0;
                            n_sc    = '0;
                            n_state = S_INIT_RD;
                        end
                        OP_READ: begin
                            heat_re    = item_ingrid;
                            heat_raddr = item_addr;
                            n_state    = S_RDH;
                        end
                        default: begin
                            n_res.done = 1'b0;
                            n_state    = S_RES;
                        end
                    endcase
                end
            end
            S_RDH: begin
                n_res.heat = r_ingrid ? r_hrd : '0;
                n_state    = S_RES;
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_INIT_RD: begin
                own_re  = 1'b1;
                n_state = S_INIT_WR;
            end
            S_INIT_WR: begin
                heat_we = 1'b1;
                if (scan_last) begin
                    n_sr    = '0;
                    n_sc    = '0;
                    n_state = S_SCAN_RD;
                end else begin
                    if (scan_last_col) begin
                        n_sc = '0;
                        n_sr = r_sr + RW'(1);
                    end else begin
                        n_sc = r_sc + CW'(1);
                    end
                    n_state = S_INIT_RD;
                end
            end
            S_SCAN_RD: begin
                heat_re = 1'b1;
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_hrd == HEAT_SEED) begin
                    n_sz    = SW'(1);
                    n_dr    = -SW'(1);
                    n_cc    = c0 - SW'(1);
                    n_chg   = 1'b0;
                    n_state = S_RING;
                end else if (scan_last) begin
                    n_state = S_RES;
                end else begin
                    if (scan_last_col) begin
                        n_sc = '0;
                        n_sr = r_sr + RW'(1);
                    end else begin
                        n_sc = r_sc + CW'(1);
                    end
                    n_state = S_SCAN_RD;
                end
            end
            S_RING, S_RING_WR: begin
                if (r_state == S_RING && t_ok) begin
                    heat_re    = 1'b1;
                    heat_raddr = t_addr;
                    n_state    = S_RING_WR;
                end else begin
                    if (r_state == S_RING_WR && cell_raise) begin
                        heat_we    = 1'b1;
                        heat_waddr = t_addr;
                        heat_wdata = cand;
                        n_chg      = 1'b1;
                    end
                    n_state = S_RING;
                    if (!last_in_row) begin
                        n_cc = row_edge ? (r_cc + SW'(1)) : (c0 + r_sz);
                    end else if (r_dr != r_sz) begin
                        n_dr = r_dr + SW'(1);
                        n_cc = c0 - r_sz;
                    end else if (n_chg && r_sz < r_lim) begin
                        n_sz  = r_sz + SW'(1);
                        n_dr  = -(r_sz + SW'(1));
                        n_cc  = c0 - (r_sz + SW'(1));
                        n_chg = 1'b0;
                    end else if (scan_last) begin
                        n_state = S_RES;
                    end else begin
                        if (scan_last_col) begin
                            n_sc = '0;
                            n_sr = r_sr + RW'(1);
                        end else begin
                            n_sc = r_sc + CW'(1);
                        end
                        n_state = S_SCAN_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sr     <= n_sr;
        r_sc     <= n_sc;
        r_rows   <= n_rows;
        r_cols   <= n_cols;
        r_lim    <= n_lim;
        r_empty  <= n_empty;
        r_sz     <= n_sz;
        r_dr     <= n_dr;
        r_cc     <= n_cc;
        r_chg    <= n_chg;
        r_ingrid <= n_ingrid;
        r_res    <= n_res;
    end

    assign o_idle      = r_state == S_IDLE;
    assign o_res_valid = r_state == S_RES;
    assign o_res       = r_res;

endmodule

// ===== sv/grid_distance_heatmap.sv =====
// Write items go from acceptance straight to the result; reads first read the heat memory.
// Compute clears each cell in use (owner read, heat write), scans it for seeds (heat read,
// check) and walks the rings: in-grid cells are read, then written if raised, others skipped.
// One item at a time; a new item is taken while the previous result waits in the output
// register. Reset (i_rst_n low, synchronous) clears the sequencer, the output register and
// the registers to mode 0, 128 rows and 128 columns; memory contents are kept.
`timescale 1ns / 1ps

// Top level of the grid distance heat map.
// Depends on gdh_pkg and gdh_engine.
module grid_distance_heatmap
    import gdh_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // row [6:0], col [13:7], owner [15:14]
    input  logic [1:0]  s_axis_tuser,   // opcode [1:0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // heat [8:0], zero [15:9]
    output logic        m_axis_tuser    // done_res [0]
);

    // Configuration registers; the user must issue writes only while the block is
    // idle, which the block does not enforce; the engine reads them directly.
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= MODE_OFF;
            r_cfg.rows <= 8'd128;
            r_cfg.cols <= 8'd128;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE: r_cfg.mode <= i_cfg_data[1:0];
                CFG_ROWS: r_cfg.rows <= i_cfg_data;
                CFG_COLS: r_cfg.cols <= i_cfg_data;
                default:  r_cfg <= r_cfg;
            endcase
        end
    end

    // Unpack the incoming item.
    t_item item;
    assign item.opcode = s_axis_tuser;
    assign item.row    = s_axis_tdata[6:0];
    assign item.col    = s_axis_tdata[13:7];
    assign item.owner  = s_axis_tdata[15:14];

    logic eng_idle, eng_res_valid, eng_res_ready;
    t_res eng_res;

    gdh_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_axis_tvalid && eng_idle),
        .i_item      (item),
        .i_cfg       (r_cfg),
        .o_idle      (eng_idle),
        .o_res_valid (eng_res_valid),
        .i_res_ready (eng_res_ready),
        .o_res       (eng_res)
    );

    assign s_axis_tready = eng_idle;

    // Output register: the engine hands its result over as soon as the register
    // is free or being emptied in the same cycle.
    logic                     r_out_valid;
    logic signed [HEAT_W-1:0] r_out_heat;
    logic                     r_out_done;

    assign eng_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_res_ready) begin
            r_out_valid <= eng_res_valid;
        end
        if (eng_res_ready && eng_res_valid) begin
            r_out_heat <= eng_res.heat;
            r_out_done <= eng_res.done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_heat};
    assign m_axis_tuser  = r_out_done;

endmodule

// ===== sv/gdh_checker.sv =====
// Port checker of the heat map result stream, bound to the top level.
// Depends on assert_macros.svh and grid_distance_heatmap.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `GDH_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    `GDH_ASSERT_ALWAYS(a_out_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `GDH_ASSERT(a_undone_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    `GDH_ASSERT(a_heat_range, i_clk, i_rst_n, m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0 && (m_axis_tdata[8] || m_axis_tdata[7:1] == 7'd0))

endmodule

bind grid_distance_heatmap gdh_checker u_gdh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/tb_grid_distance_heatmap.sv =====
// Self-checking bench for grid_distance_heatmap: a queue-fed stream driver, a result
// monitor and a behavioral heat map predictor. Depends on gdh_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_grid_distance_heatmap;
    import gdh_pkg::*;

    localparam int ROWS_MAX = 128;
    localparam int COLS_MAX = 128;
    localparam int CELL_COUNT = ROWS_MAX * COLS_MAX;
    localparam int WINDOW = 8;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 75;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [1:0] MODE_NOSEED = 2'd3;

    typedef struct {
        logic [1:0] opcode;
        logic [6:0] row;
        logic [6:0] col;
        logic [1:0] owner;
    } t_grid_op;

    typedef struct {
        logic [8:0] heat;
        logic       done;
    } t_heat_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    grid_distance_heatmap DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Predictor state: owner signs, heat values and the shadow of the registers.
    int owner_sign [CELL_COUNT];
    int heat_map [CELL_COUNT];
    logic [1:0] shadow_mode;
    logic [7:0] shadow_rows;
    logic [7:0] shadow_cols;

    t_grid_op    pending_ops[$];
    t_heat_reply expected_replies[$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          error_count;
    int          cycle_count;

    // Each seed raises a ring cell only to minus its distance, floored at the 9-bit minimum.
    function automatic bit raise_cell(int r, int c, int mdist);
        int cand;
        cand = (mdist > 256) ? -256 : -mdist;
        if (heat_map[r * COLS_MAX + c] < cand) begin
            heat_map[r * COLS_MAX + c] = cand;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Walk one square ring around a seed; report whether any cell went up.
    function automatic bit grow_ring(int r0, int c0, int sz, int rows, int cols);
        bit changed;
        int r;
        int dr_abs;
        changed = 1'b0;
        for (int dr = -sz; dr <= sz; dr++) begin
            r = r0 + dr;
            dr_abs = (dr < 0) ? -dr : dr;
            if (r < 0 || r >= rows)
                continue;
            if (dr_abs == sz) begin
                for (int c = c0 - sz; c <= c0 + sz; c++) begin
                    if (c >= 0 && c < cols &&
                        raise_cell(r, c, sz + ((c < c0) ? c0 - c : c - c0)))
                        changed = 1'b1;
                end
            end else begin
                if (c0 - sz >= 0 && raise_cell(r, c0 - sz, sz + dr_abs))
                    changed = 1'b1;
                if (c0 + sz < cols && raise_cell(r, c0 + sz, sz + dr_abs))
                    changed = 1'b1;
            end
        end
        return changed;
    endfunction

    function automatic void build_heat_map();
        int rows;
        int cols;
        int empty_heat;
        int o;
        int h;
        rows = (shadow_rows < 1) ? 1 : (shadow_rows > ROWS_MAX) ? ROWS_MAX : shadow_rows;
        cols = (shadow_cols < 1) ? 1 : (shadow_cols > COLS_MAX) ? COLS_MAX : shadow_cols;
        empty_heat = (rows + cols > 256) ? -256 : -(rows + cols);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                o = owner_sign[r * COLS_MAX + c];
                h = 0;
                if (shadow_mode != MODE_OFF) begin
                    if (o == 0)
                        h = empty_heat;
                    else if ((o > 0 && shadow_mode == MODE_POS) ||
                             (o < 0 && shadow_mode == MODE_NEG))
                        h = 1;
                end
                heat_map[r * COLS_MAX + c] = h;
            end
        end
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                if (heat_map[r * COLS_MAX + c] != 1)
                    continue;
                for (int sz = 1; sz <= rows + cols; sz++) begin
                    if (!grow_ring(r, c, sz, rows, cols))
                        break;
                end
            end
        end
    endfunction

    // Apply one accepted transaction to the predictor and queue the reply it must produce.
    function automatic void predict_reply(t_grid_op op);
        t_heat_reply rep;
        int idx;
        idx = op.row * COLS_MAX + op.col;
        rep.heat = '0;
        rep.done = 1'b1;
        case (op.opcode)
            OP_WRITE: begin
                // Only the sign counts, so the pattern 2'b10 is stored as negative too.
                owner_sign[idx] = (op.owner == 2'b00) ? 0 : (op.owner[1] ? -1 : 1);
            end
            OP_COMPUTE: build_heat_map();
            OP_READ:    rep.heat = heat_map[idx][8:0];
            default:    rep.done = 1'b0;
        endcase
        expected_replies.push_back(rep);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Item driver: predicts on acceptance, then offers the next queued item or idles.
    t_grid_op drive_op;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_reply(drive_op);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    drive_op = pending_ops.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {drive_op.owner, drive_op.col, drive_op.row};
                    s_axis_tuser  <= drive_op.opcode;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, every reply checked against the oldest prediction.
    t_heat_reply want;
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected reply heat=%0d done=%0b", $realtime,
                         $signed(m_axis_tdata[8:0]), m_axis_tuser);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (m_axis_tdata !== {7'd0, want.heat} || m_axis_tuser !== want.done) begin
                    $display("%0t: expected heat=%0d done=%0b, got data=%h done=%0b",
                             $realtime, $signed(want.heat), want.done, m_axis_tdata,
                             m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    function automatic void queue_op(logic [1:0] opc, int r, int c, logic [1:0] own);
        t_grid_op op;
        op.opcode = opc;
        op.row = r[6:0];
        op.col = c[6:0];
        op.owner = own;
        pending_ops.push_back(op);
    endfunction

    // Wait until every queued transaction has been accepted and answered, then let the
    // compute sequencer settle before anything touches the registers.
    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_axis_tvalid || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (index)
            CFG_MODE: shadow_mode = value[1:0];
            CFG_ROWS: shadow_rows = value;
            CFG_COLS: shadow_cols = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_region(logic [1:0] m, logic [7:0] r, logic [7:0] c);
        write_reg(CFG_MODE, {6'd0, m});
        write_reg(CFG_ROWS, r);
        write_reg(CFG_COLS, c);
    endtask

    // Random traffic mostly aimed at the region in use. Writes may land anywhere; reads
    // stay inside the corner window, whose heat cells the compute over the window has written.
    task automatic random_items(int count, int rows, int cols);
        int pick;
        int r;
        int c;
        int rr;
        int rc;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 70) begin
                r = $urandom_range(rows - 1);
                c = $urandom_range(cols - 1);
                rr = r;
                rc = c;
            end else begin
                r = $urandom_range(127);
                c = $urandom_range(127);
                rr = $urandom_range(WINDOW - 1);
                rc = $urandom_range(WINDOW - 1);
            end
            if (pick < 50)
                queue_op(OP_WRITE, r, c, 2'($urandom_range(3)));
            else if (pick < 54)
                queue_op(OP_COMPUTE, $urandom_range(127), $urandom_range(127),
                         2'($urandom_range(3)));
            else if (pick < 96)
                queue_op(OP_READ, rr, rc, 2'($urandom_range(3)));
            else
                queue_op(OP_NONE, r, c, 2'($urandom_range(3)));
        end
    endtask

    int phase_idle [4] = '{0, 55, 0, 34};
    int phase_stall [4] = '{0, 0, 55, 34};
    logic [1:0] phase_mode [4] = '{MODE_POS, MODE_NEG, MODE_NOSEED, MODE_POS};
    int rows_pick;
    int cols_pick;

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        shadow_mode = MODE_OFF;
        shadow_rows = 8'd128;
        shadow_cols = 8'd128;
        foreach (owner_sign[i]) begin
            owner_sign[i] = 0;
            heat_map[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load the owner cells of the corner window, the first row and the first column, so
        // no compute below ever sees an unwritten cell. They are negative cells except four
        // positive seeds, three with an empty neighbor, so growth from every seed dies early.
        for (int r = 0; r < WINDOW; r++)
            for (int c = 0; c < WINDOW; c++)
                queue_op(OP_WRITE, r, c, OWN_NEG);
        for (int c = WINDOW; c < COLS_MAX; c++)
            queue_op(OP_WRITE, 0, c, OWN_NEG);
        for (int r = WINDOW; r < ROWS_MAX; r++)
            queue_op(OP_WRITE, r, 0, OWN_NEG);
        queue_op(OP_WRITE, 0, 0, OWN_POS);
        queue_op(OP_WRITE, 1, 0, OWN_EMPTY);
        queue_op(OP_WRITE, 60, 0, OWN_POS);
        queue_op(OP_WRITE, 61, 0, OWN_EMPTY);
        queue_op(OP_WRITE, 127, 0, OWN_POS);
        queue_op(OP_WRITE, 126, 0, 2'b10);
        queue_op(OP_WRITE, 0, 100, OWN_POS);
        queue_op(OP_WRITE, 0, 99, OWN_EMPTY);
        queue_op(OP_WRITE, 0, 127, OWN_EMPTY);
        wait_drained();

        // Heat off over the corner window writes every heat cell that random reads touch.
        set_region(MODE_OFF, 8'(WINDOW), 8'(WINDOW));
        queue_op(OP_COMPUTE, 0, 0, 2'b00);
        queue_op(OP_READ, WINDOW - 1, WINDOW - 1, 2'b00);
        wait_drained();

        // Oversized rows saturate to the full height; one column.
        set_region(MODE_POS, 8'd255, 8'd1);
        queue_op(OP_COMPUTE, 127, 127, 2'b11);
        queue_op(OP_READ, 0, 0, 2'b00);
        queue_op(OP_READ, 1, 0, 2'b00);
        queue_op(OP_READ, 61, 0, 2'b00);
        queue_op(OP_READ, 64, 0, 2'b00);
        queue_op(OP_READ, 126, 0, 2'b00);
        queue_op(OP_READ, 127, 0, 2'b00);
        queue_op(OP_NONE, 127, 0, 2'b11);
        wait_drained();

        // Oversized columns saturate to the full width; one row, negative cells as seeds.
        set_region(MODE_NEG, 8'd1, 8'd200);
        queue_op(OP_COMPUTE, 0, 0, 2'b00);
        queue_op(OP_READ, 0, 0, 2'b00);
        queue_op(OP_READ, 0, 99, 2'b00);
        queue_op(OP_READ, 0, 100, 2'b00);
        queue_op(OP_READ, 0, 127, 2'b00);
        wait_drained();

        // Zero sizes saturate to one cell; with no seed mode only the empty value appears.
        set_region(MODE_NOSEED, 8'd0, 8'd0);
        queue_op(OP_WRITE, 0, 0, OWN_EMPTY);
        queue_op(OP_COMPUTE, 0, 0, 2'b00);
        queue_op(OP_READ, 0, 0, 2'b00);
        wait_drained();

        // Random phases, each on a small region and one idling pattern. Halfway through,
        // the sender holds off until every outstanding reply is back.
        for (int p = 0; p < 8; p++) begin
            rows_pick = (p == 7) ? 1 : $urandom_range(1, WINDOW - 1);
            cols_pick = (p == 6) ? 1 : $urandom_range(1, WINDOW - 1);
            set_region(phase_mode[p % 4], rows_pick[7:0], cols_pick[7:0]);
            send_idle_pct = phase_idle[p % 4];
            recv_stall_pct = phase_stall[p % 4];
            random_items(PHASE_ITEMS, rows_pick, cols_pick);
            wait_drained();
            random_items(PHASE_ITEMS, rows_pick, cols_pick);
            wait_drained();
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
